[design/esch_pkg.sv]
package esch_pkg;

    // Index width of the search word, wide enough for 16 floors
    localparam int IDX_W      = 4;
    localparam int BTN_W      = 3;
    localparam int OUT_FLOORS = 4;
    localparam int TABLE_W    = BTN_W * OUT_FLOORS;

    localparam logic [BTN_W-1:0] BTN_UP   = 3'b001;
    localparam logic [BTN_W-1:0] BTN_DOWN = 3'b010;
    localparam logic [BTN_W-1:0] BTN_CAB  = 3'b100;

    localparam logic [1:0] DIR_UP   = 2'b01;
    localparam logic [1:0] DIR_DOWN = 2'b11;

    localparam logic [2:0] GOAL_NONE = 3'b111;

    typedef enum logic [1:0] {
        KIND_SCAN    = 2'd0,
        KIND_CLR_ONE = 2'd1,
        KIND_CLR_ALL = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SWEEP,
        ST_DONE
    } t_state;

    // Table update broadcast to every floor cell
    typedef struct packed {
        logic               set_en;
        logic [TABLE_W-1:0] set_bits;
        logic               clr_en;
        logic [IDX_W-1:0]   clr_idx;
        logic               clr_all;
    } t_cmd;

    // Search windows, held for the whole sweep
    typedef struct packed {
        logic             p1_en;
        logic [IDX_W-1:0] p1_lo;
        logic [IDX_W-1:0] p1_hi;
        logic [BTN_W-1:0] p1_mask;
        logic             p2_en;
        logic [IDX_W-1:0] p2_lo;
        logic [IDX_W-1:0] p2_hi;
        logic             pick_last;
    } t_ctx;

    // Search word handed from cell to cell
    typedef struct packed {
        logic             vld;
        logic             p1_hit;
        logic [IDX_W-1:0] p1_idx;
        logic             p2_hit;
        logic [IDX_W-1:0] p2_idx;
        logic             p3_hit;
        logic [IDX_W-1:0] p3_idx;
    } t_carry;

endpackage

[design/esch_if.sv]
interface esch_req_if;
    logic              valid;
    logic              ready;
    logic [1:0]        kind;
    logic signed [2:0] floor_index;
    logic              between_floors;
    logic              stopped;
    logic signed [1:0] travel_dir;
    logic [11:0]       call_buttons;

    modport source (
        output valid, kind, floor_index, between_floors, stopped, travel_dir, call_buttons,
        input  ready
    );
    modport sink (
        input  valid, kind, floor_index, between_floors, stopped, travel_dir, call_buttons,
        output ready
    );
endinterface

interface esch_res_if;
    logic              valid;
    logic              ready;
    logic signed [2:0] target_floor;
    logic [11:0]       pending_orders;

    modport source (
        output valid, target_floor, pending_orders,
        input  ready
    );
    modport sink (
        input  valid, target_floor, pending_orders,
        output ready
    );
endinterface

[design/elevator_order_scheduler.sv]
// Order table and goal selection for a collective-control elevator. Each floor's
// hall-up, hall-down and cab orders live in a floor cell; the cells form a chain through
// which a search word walks one floor per cycle, collecting the first same-direction or
// cab order before the goal, the first order from the goal onward and the lowest floor
// with any order. One request at a time: a scan result passes the walk along the cell chain,
// then a register for the new goal, then the result register; clears and ignored scans
// go straight to the result register. The next request is taken the cycle after a result
// is loaded. Every request returns one result with the goal (-1 for none) and the
// first four floors of the table. A new request is taken while the previous result still
// waits at the output.
module elevator_order_scheduler #(
    parameter int FLOORS = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    esch_req_if.sink    i_req,
    esch_res_if.source  o_res
);

    localparam int GW = $clog2(FLOORS);

    esch_pkg::t_state                 r_state;
    esch_pkg::t_state                 n_state;
    logic                             r_kick;
    esch_pkg::t_ctx                   r_ctx;
    esch_pkg::t_ctx                   n_ctx;
    logic                             r_goal_vld;
    logic                             n_goal_vld;
    logic [GW-1:0]                    r_goal_idx;
    logic [GW-1:0]                    n_goal_idx;
    logic                             r_out_vld;
    logic [2:0]                       r_out_goal;
    logic [esch_pkg::TABLE_W-1:0]     r_out_pend;

    esch_pkg::t_cmd                   w_cmd;
    esch_pkg::t_carry                 w_chain [FLOORS+1];
    logic [esch_pkg::BTN_W-1:0]       w_bits  [FLOORS];
    logic [esch_pkg::TABLE_W-1:0]     w_pend;
    logic                             w_accept;
    logic                             w_fl_ok;
    logic                             w_scan_ok;
    logic                             w_load;
    logic                             w_sweep_end;
    logic [esch_pkg::IDX_W-1:0]       w_gi;
    logic [esch_pkg::IDX_W-1:0]       w_sel;
    logic [4:0]                       w_cur;
    logic [4:0]                       w_btw;
    logic [4:0]                       w_goal5;
    logic [4:0]                       w_up_start;
    logic [4:0]                       w_dn_start;
    logic [esch_pkg::IDX_W:0]         w_gi_next;
    logic [3:0]                       w_out_idx;

    assign w_accept  = i_req.valid && i_req.ready;
    assign w_fl_ok   = !i_req.floor_index[2] && (32'(i_req.floor_index[1:0]) < FLOORS);
    assign w_scan_ok = (i_req.kind == esch_pkg::KIND_SCAN) && w_fl_ok && !i_req.stopped;

    // search windows from the current floor, direction and goal
    assign w_gi       = esch_pkg::IDX_W'(r_goal_idx);
    assign w_cur      = {3'b000, i_req.floor_index[1:0]};
    assign w_btw      = {4'b0000, i_req.between_floors};
    assign w_goal5    = 5'(w_gi);
    assign w_up_start = w_cur + w_btw;
    assign w_dn_start = w_cur - w_btw;
    assign w_gi_next  = {1'b0, w_gi} + 5'd1;

    always_comb begin
        n_ctx = '0;
        if (r_goal_vld && (i_req.travel_dir == esch_pkg::DIR_UP)) begin
            n_ctx.p1_en     = w_up_start < w_goal5;
            n_ctx.p1_lo     = w_up_start[esch_pkg::IDX_W-1:0];
            n_ctx.p1_hi     = w_gi - 4'd1;
            n_ctx.p1_mask   = esch_pkg::BTN_UP | esch_pkg::BTN_CAB;
            n_ctx.p2_en     = 1'b1;
            n_ctx.p2_lo     = w_gi;
            n_ctx.p2_hi     = '1;
            n_ctx.pick_last = 1'b0;
        end else if (r_goal_vld && (i_req.travel_dir == esch_pkg::DIR_DOWN)) begin
            // start at or below the goal, or at -1 when leaving floor 0, leaves the window empty
            n_ctx.p1_en     = w_cur > (w_goal5 + w_btw);
            n_ctx.p1_lo     = w_gi_next[esch_pkg::IDX_W-1:0];
            n_ctx.p1_hi     = w_dn_start[esch_pkg::IDX_W-1:0];
            n_ctx.p1_mask   = esch_pkg::BTN_DOWN | esch_pkg::BTN_CAB;
            n_ctx.p2_en     = 1'b1;
            n_ctx.p2_lo     = '0;
            n_ctx.p2_hi     = w_gi;
            n_ctx.pick_last = 1'b1;
        end
    end

    always_comb begin
        w_cmd          = '0;
        w_cmd.set_bits = i_req.call_buttons;
        w_cmd.clr_idx  = esch_pkg::IDX_W'(i_req.floor_index[1:0]);
        w_cmd.set_en   = w_accept && w_scan_ok;
        w_cmd.clr_en   = w_accept && (i_req.kind == esch_pkg::KIND_CLR_ONE) && w_fl_ok;
        w_cmd.clr_all  = w_accept && (i_req.kind == esch_pkg::KIND_CLR_ALL);
    end

    // valid flag is the top field of the search word
    assign w_chain[0] = {r_kick, {($bits(esch_pkg::t_carry) - 1){1'b0}}};

    genvar g;
    generate
        for (g = 0; g < FLOORS; g++) begin : g_cell
            esch_cell #(
                .FLOOR (g)
            ) u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_cmd   (w_cmd),
                .i_ctx   (r_ctx),
                .i_carry (w_chain[g]),
                .o_carry (w_chain[g+1]),
                .o_bits  (w_bits[g])
            );
        end
        for (g = 0; g < esch_pkg::OUT_FLOORS; g++) begin : g_pend
            if (g < FLOORS) begin : g_on
                assign w_pend[esch_pkg::BTN_W*g +: esch_pkg::BTN_W] = w_bits[g];
            end else begin : g_off
                assign w_pend[esch_pkg::BTN_W*g +: esch_pkg::BTN_W] = '0;
            end
        end
    endgenerate

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            esch_pkg::ST_IDLE: begin
                if (w_accept) begin
                    n_state = w_scan_ok ? esch_pkg::ST_SWEEP : esch_pkg::ST_DONE;
                end
            end
            esch_pkg::ST_SWEEP: begin
                if (w_chain[FLOORS].vld) begin
                    n_state = esch_pkg::ST_DONE;
                end
            end
            esch_pkg::ST_DONE: begin
                if (!r_out_vld || o_res.ready) begin
                    n_state = esch_pkg::ST_IDLE;
                end
            end
            default: n_state = esch_pkg::ST_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        i_req.ready = 1'b0;
        w_sweep_end = 1'b0;
        w_load      = 1'b0;
        case (r_state)
            esch_pkg::ST_IDLE:  i_req.ready = 1'b1;
            esch_pkg::ST_SWEEP: w_sweep_end = w_chain[FLOORS].vld;
            esch_pkg::ST_DONE:  w_load      = !r_out_vld || o_res.ready;
            default: begin
                i_req.ready = 1'b0;
            end
        endcase
    end

    always_comb begin
        if (w_chain[FLOORS].p1_hit) begin
            w_sel = w_chain[FLOORS].p1_idx;
        end else if (w_chain[FLOORS].p2_hit) begin
            w_sel = w_chain[FLOORS].p2_idx;
        end else begin
            w_sel = w_chain[FLOORS].p3_idx;
        end
    end

    always_comb begin
        n_goal_vld = r_goal_vld;
        n_goal_idx = r_goal_idx;
        if (w_sweep_end) begin
            n_goal_vld = w_chain[FLOORS].p1_hit || w_chain[FLOORS].p2_hit
                         || w_chain[FLOORS].p3_hit;
            n_goal_idx = GW'(w_sel);
        end
    end

    assign w_out_idx = 4'(r_goal_idx);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= esch_pkg::ST_IDLE;
            r_kick     <= 1'b0;
            r_goal_vld <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_kick     <= w_accept && w_scan_ok;
            r_goal_vld <= n_goal_vld;
            if (w_load) begin
                r_out_vld <= 1'b1;
            end else if (o_res.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_goal_idx <= n_goal_idx;
        if (w_accept) begin
            r_ctx <= n_ctx;
        end
        if (w_load) begin
            r_out_goal <= r_goal_vld ? w_out_idx[2:0] : esch_pkg::GOAL_NONE;
            r_out_pend <= w_pend;
        end
    end

    assign o_res.valid          = r_out_vld;
    assign o_res.target_floor   = r_out_goal;
    assign o_res.pending_orders = r_out_pend;

endmodule

[design/esch_cell.sv]
module esch_cell #(
    parameter int FLOOR = 0
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  esch_pkg::t_cmd                i_cmd,
    input  esch_pkg::t_ctx                i_ctx,
    input  esch_pkg::t_carry              i_carry,
    output esch_pkg::t_carry              o_carry,
    output logic [esch_pkg::BTN_W-1:0]    o_bits
);

    localparam logic [esch_pkg::IDX_W-1:0] FL = esch_pkg::IDX_W'(FLOOR);

    logic [esch_pkg::BTN_W-1:0] r_bits;
    logic [esch_pkg::BTN_W-1:0] n_bits;
    logic [esch_pkg::BTN_W-1:0] w_btn;
    esch_pkg::t_carry           r_carry;
    esch_pkg::t_carry           n_carry;
    logic                       w_any;
    logic                       w_p1;
    logic                       w_p2;

    generate
        if (FLOOR < esch_pkg::OUT_FLOORS) begin : g_btn
            assign w_btn = i_cmd.set_bits[esch_pkg::BTN_W*FLOOR +: esch_pkg::BTN_W];
        end else begin : g_nobtn
            assign w_btn = '0;
        end
    endgenerate

    always_comb begin
        n_bits = r_bits;
        if (i_cmd.clr_all) begin
            n_bits = '0;
        end else if (i_cmd.clr_en && (i_cmd.clr_idx == FL)) begin
            n_bits = '0;
        end else if (i_cmd.set_en) begin
            n_bits = r_bits | w_btn;
        end
    end

    assign w_any = |r_bits;
    assign w_p1  = i_ctx.p1_en && (FL >= i_ctx.p1_lo) && (FL <= i_ctx.p1_hi)
                   && |(r_bits & i_ctx.p1_mask);
    assign w_p2  = i_ctx.p2_en && (FL >= i_ctx.p2_lo) && (FL <= i_ctx.p2_hi) && w_any;

    // downward searches keep the highest hit, everything else the lowest
    always_comb begin
        n_carry = i_carry;
        if (w_p1 && (i_ctx.pick_last || !i_carry.p1_hit)) begin
            n_carry.p1_hit = 1'b1;
            n_carry.p1_idx = FL;
        end
        if (w_p2 && (i_ctx.pick_last || !i_carry.p2_hit)) begin
            n_carry.p2_hit = 1'b1;
            n_carry.p2_idx = FL;
        end
        if (w_any && !i_carry.p3_hit) begin
            n_carry.p3_hit = 1'b1;
            n_carry.p3_idx = FL;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bits  <= '0;
            r_carry <= '0;
        end else begin
            r_bits  <= n_bits;
            r_carry <= n_carry;
        end
    end

    assign o_carry = r_carry;
    assign o_bits  = r_bits;

endmodule

[design/esch_checker.sv]
module esch_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [2:0]  i_target_floor,
    input logic [11:0] i_pending_orders
);

    // nothing is reported right out of reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    // one request in flight: no acceptance on the cycle after one
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready)
        else $error("request accepted while another is in flight");

    // a result is never produced on the cycle right after its request
    a_no_instant_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready && !i_out_valid) |=> !i_out_valid)
        else $error("result appeared without processing time");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_target_floor) && $stable(i_pending_orders)))
        else $error("stalled result changed");

endmodule

bind elevator_order_scheduler esch_checker u_esch_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_valid       (i_req.valid),
    .i_in_ready       (i_req.ready),
    .i_out_valid      (o_res.valid),
    .i_out_ready      (o_res.ready),
    .i_target_floor   (o_res.target_floor),
    .i_pending_orders (o_res.pending_orders)
);
